@@ hw/rtl/json_string_unescape_assert.svh @@
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/jsu_pkg.sv @@
package jsu_pkg;

    localparam int GROUP_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 6;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CONTROL = 3'd1;
    localparam logic [2:0] ERR_ESCAPE  = 3'd2;
    localparam logic [2:0] ERR_HEX     = 3'd3;
    localparam logic [2:0] ERR_UNTERM  = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_AFTER_HIGH,
        PH_AFTER_HIGH_BS,
        PH_LOW_HEX
    } phase_t;

    // utf-8 form of one code point, byte 0 first
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      len;
    } enc_t;

    // all results caused by one input item
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [2:0]                  n;
        logic [1:0]                  tail_kind;
        logic [2:0]                  tail_err;
    } grp_t;

    function automatic enc_t utf8_enc(input logic [20:0] cp);
        enc_t e;
        e.data = '0;
        if (cp < 21'h80) begin
            e.data[0] = cp[7:0];
            e.len     = 3'd1;
        end else if (cp < 21'h800) begin
            e.data[0] = 8'hC0 | {3'b000, cp[10:6]};
            e.data[1] = 8'h80 | {2'b00, cp[5:0]};
            e.len     = 3'd2;
        end else if (cp < 21'h10000) begin
            e.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
            e.data[1] = 8'h80 | {2'b00, cp[11:6]};
            e.data[2] = 8'h80 | {2'b00, cp[5:0]};
            e.len     = 3'd3;
        end else begin
            e.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
            e.data[1] = 8'h80 | {2'b00, cp[17:12]};
            e.data[2] = 8'h80 | {2'b00, cp[11:6]};
            e.data[3] = 8'h80 | {2'b00, cp[5:0]};
            e.len     = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ hw/rtl/jsu_core.sv @@
module jsu_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     in_byte,
    input  logic           text_end,
    output jsu_pkg::grp_t  grp,
    output logic           grp_en
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] hi_reg, hi_next;

    logic        hv_ok;
    logic [3:0]  hv;
    logic [15:0] acc_sh;

    phase_t      bd_phase;
    logic        bd_raw, bd_t;
    logic [1:0]  bd_kind;
    logic [2:0]  bd_err;

    phase_t      es_phase;
    logic        es_raw, es_t;
    logic [7:0]  es_byte;

    logic        a_en, a_comb, b_en, t_en;
    logic [1:0]  t_kind;
    logic [2:0]  t_err;
    enc_t        a_enc, b_enc;
    logic [20:0] comb_cp;
    logic [2:0]  la, lb;

    // hex digit value
    always_comb
    begin
        hv_ok = 1'b1;
        hv    = 4'd0;
        case (in_byte) inside
            [8'h30:8'h39]: hv = in_byte[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: hv = in_byte[3:0] + 4'd9;
            default:       hv_ok = 1'b0;
        endcase
    end

    assign acc_sh  = {acc_reg[11:0], hv};
    assign comb_cp = 21'h10000 + 21'({hi_reg[9:0], acc_sh[9:0]});

    // byte inside the string body
    always_comb
    begin
        bd_phase = PH_BODY;
        bd_raw   = 1'b0;
        bd_t     = 1'b0;
        bd_kind  = KIND_DATA;
        bd_err   = ERR_NONE;
        if (in_byte == CH_QUOTE) begin
            bd_phase = PH_IDLE;
            bd_t     = 1'b1;
            bd_kind  = KIND_CLOSE;
        end else if (in_byte < 8'h20) begin
            bd_phase = PH_IDLE;
            bd_t     = 1'b1;
            bd_kind  = KIND_ERROR;
            bd_err   = ERR_CONTROL;
        end else if (in_byte == CH_BSL) begin
            bd_phase = PH_ESC;
        end else begin
            bd_raw = 1'b1;
        end
    end

    // escape letter
    always_comb
    begin
        es_phase = PH_BODY;
        es_raw   = 1'b1;
        es_t     = 1'b0;
        es_byte  = in_byte;
        case (in_byte)
            8'h22, 8'h5C, 8'h2F: es_byte = in_byte;
            8'h62:   es_byte = 8'h08;
            8'h66:   es_byte = 8'h0C;
            8'h6E:   es_byte = 8'h0A;
            8'h72:   es_byte = 8'h0D;
            8'h74:   es_byte = 8'h09;
            CH_U:
            begin
                es_phase = PH_HEX;
                es_raw   = 1'b0;
            end
            default:
            begin
                es_phase = PH_IDLE;
                es_raw   = 1'b0;
                es_t     = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        a_en       = 1'b0;
        a_comb     = 1'b0;
        b_en       = 1'b0;
        b_enc      = '0;
        t_en       = 1'b0;
        t_kind     = KIND_DATA;
        t_err      = ERR_NONE;

        if (text_end) begin
            phase_next = PH_IDLE;
            case (phase_reg)
                PH_BODY, PH_ESC:
                begin
                    t_en = 1'b1;
                    t_err = ERR_UNTERM;
                end
                PH_HEX:
                begin
                    t_en = 1'b1;
                    t_err = ERR_HEX;
                end
                PH_AFTER_HIGH, PH_AFTER_HIGH_BS:
                begin
                    a_en  = 1'b1;
                    t_en  = 1'b1;
                    t_err = ERR_UNTERM;
                end
                PH_LOW_HEX:
                begin
                    a_en  = 1'b1;
                    t_en  = 1'b1;
                    t_err = ERR_HEX;
                end
                default: phase_next = PH_IDLE;
            endcase
            if (t_en) begin
                t_kind = KIND_ERROR;
            end
        end else begin
            case (phase_reg)
                PH_BODY, PH_AFTER_HIGH:
                begin
                    if (phase_reg == PH_AFTER_HIGH && in_byte == CH_BSL) begin
                        phase_next = PH_AFTER_HIGH_BS;
                    end else begin
                        a_en       = (phase_reg == PH_AFTER_HIGH);
                        hi_next    = 16'd0;
                        phase_next = bd_phase;
                        b_en       = bd_raw;
                        b_enc.data = {24'd0, in_byte};
                        b_enc.len  = 3'd1;
                        t_en       = bd_t;
                        t_kind     = bd_kind;
                        t_err      = bd_err;
                    end
                end
                PH_ESC, PH_AFTER_HIGH_BS:
                begin
                    if (phase_reg == PH_AFTER_HIGH_BS && in_byte == CH_U) begin
                        phase_next = PH_LOW_HEX;
                        acc_next   = 16'd0;
                        cnt_next   = 2'd0;
                    end else begin
                        a_en       = (phase_reg == PH_AFTER_HIGH_BS);
                        hi_next    = 16'd0;
                        phase_next = es_phase;
                        b_en       = es_raw;
                        b_enc.data = {24'd0, es_byte};
                        b_enc.len  = 3'd1;
                        t_en       = es_t;
                        t_kind     = es_t ? KIND_ERROR : KIND_DATA;
                        t_err      = es_t ? ERR_ESCAPE : ERR_NONE;
                        acc_next   = 16'd0;
                        cnt_next   = 2'd0;
                    end
                end
                PH_HEX, PH_LOW_HEX:
                begin
                    if (!hv_ok) begin
                        a_en       = (phase_reg == PH_LOW_HEX);
                        phase_next = PH_IDLE;
                        t_en       = 1'b1;
                        t_kind     = KIND_ERROR;
                        t_err      = ERR_HEX;
                    end else if (cnt_reg != 2'd3) begin
                        acc_next = acc_sh;
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        acc_next = 16'd0;
                        cnt_next = 2'd0;
                        if (phase_reg == PH_LOW_HEX && acc_sh >= 16'hDC00
                            && acc_sh < 16'hE000) begin
                            // surrogate pair
                            a_en       = 1'b1;
                            a_comb     = 1'b1;
                            hi_next    = 16'd0;
                            phase_next = PH_BODY;
                        end else begin
                            a_en    = (phase_reg == PH_LOW_HEX);
                            hi_next = 16'd0;
                            if (acc_sh >= 16'hD800 && acc_sh < 16'hDC00) begin
                                hi_next    = acc_sh;
                                phase_next = PH_AFTER_HIGH;
                            end else begin
                                phase_next = PH_BODY;
                                b_en       = 1'b1;
                                b_enc      = utf8_enc((acc_sh == 16'd0) ? 21'hFFFD
                                                                        : {5'd0, acc_sh});
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = (in_byte == CH_QUOTE) ? PH_BODY : PH_IDLE;
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                    hi_next    = 16'd0;
                end
            endcase
        end

        if (phase_next == PH_IDLE) begin
            acc_next = 16'd0;
            cnt_next = 2'd0;
            hi_next  = 16'd0;
        end
    end

    assign a_enc = utf8_enc(a_comb ? comb_cp : {5'd0, hi_reg});
    assign la    = a_en ? a_enc.len : 3'd0;
    assign lb    = b_en ? b_enc.len : 3'd0;

    // place the pieces one after another
    always_comb
    begin : pack_grp
        logic [2:0] ii;
        logic [2:0] jj;
        grp.data = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            ii = 3'(i);
            jj = ii - la;
            if (ii < la) begin
                grp.data[i] = a_enc.data[ii[1:0]];
            end else if (jj < lb) begin
                grp.data[i] = b_enc.data[jj[1:0]];
            end
        end
        grp.n         = la + lb + {2'd0, t_en};
        grp.tail_kind = t_kind;
        grp.tail_err  = t_err;
    end

    assign grp_en = take && (grp.n != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            hi_reg    <= 16'd0;
        end else if (take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
        end
    end

endmodule

@@ hw/rtl/json_string_unescape.sv @@
// JSON string unescaper. Takes the text one byte per item, skips bytes until an opening
// quote, then turns the string body into UTF-8 data bytes (simple escapes, \uXXXX with
// surrogate pairs, U+0000 given as U+FFFD) and ends the string with a close or an error
// result. An input item is taken every cycle while the result queue has room; the results
// of one item (up to six) are written together into a queue of GROUP_DEPTH entries and
// leave one per cycle while out_ready is high, and input stalls only once the queue is full.
// An item's results are registered in the queue before they are shown, behind the results
// of earlier items.
`include "json_string_unescape_assert.svh"

module json_string_unescape #(
    parameter int GROUP_DEPTH = jsu_pkg::GROUP_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic [2:0] error_code,
    output logic       last
);
    import jsu_pkg::*;

    localparam int PW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CW = $clog2(GROUP_DEPTH + 1);

    grp_t          grp;
    logic          grp_en;
    grp_t          q_mem [GROUP_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    pos_reg, pos_next;
    grp_t          head;
    logic          at_last, is_tail, push, pop, out_take;

    jsu_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (in_valid && in_ready),
        .in_byte  (in_byte),
        .text_end (text_end),
        .grp      (grp),
        .grp_en   (grp_en)
    );

    assign in_ready  = (cnt_reg < CW'(GROUP_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign head      = q_mem[rd_ptr_reg];
    assign at_last   = (pos_reg == head.n - 3'd1);
    assign is_tail   = at_last && (head.tail_kind != KIND_DATA);
    assign out_take  = out_valid && out_ready;
    assign push      = grp_en;
    assign pop       = out_take && at_last;

    assign out_byte   = is_tail ? 8'd0 : head.data[pos_reg];
    assign kind       = is_tail ? head.tail_kind : KIND_DATA;
    assign error_code = is_tail ? head.tail_err : ERR_NONE;
    assign last       = at_last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        pos_next    = pos_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(GROUP_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(GROUP_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (out_take) begin
            pos_next = at_last ? 3'd0 : pos_reg + 3'd1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            pos_reg    <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem[wr_ptr_reg] <= grp;
        end
    end

    `JSU_ASSERT_NOW(a_grp_size, push, (grp.n != 3'd0) && (grp.n <= 3'd6), "bad group size")
    `JSU_ASSERT_NOW(a_pos_in_grp, out_valid, pos_reg < head.n, "position past group end")
    `JSU_ASSERT_NOW(a_err_kind, out_valid, (kind == KIND_ERROR) == (error_code != ERR_NONE), "error code without error kind")
    `JSU_ASSERT_NEXT(a_drain, pop && !push && (cnt_reg == CW'(1)), !out_valid, "queue not empty after last pop")

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 235;

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;
    localparam logic [7:0] CH_U   = 8'h75;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
        logic       last;
    } utf8_res_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } text_item_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } chk_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        chk_t       chk;
        utf8_res_t  want;
    } row_t;

    localparam row_t DIR_ROWS [25] = '{
        '{8'h00,  1'b0, CHK_NONE,    '0},
        '{8'h00,  1'b1, CHK_NONE,    '0},
        '{QUOTE,  1'b0, CHK_NONE,    '0},
        '{8'h41,  1'b0, CHK_ONE,     '{8'h41, KIND_DATA, ERR_NONE, 1'b1}},
        '{8'hFF,  1'b0, CHK_ONE,     '{8'hFF, KIND_DATA, ERR_NONE, 1'b1}},
        '{BSLASH, 1'b0, CHK_NONE,    '0},
        '{8'h6E,  1'b0, CHK_ONE,     '{8'h0A, KIND_DATA, ERR_NONE, 1'b1}},
        '{BSLASH, 1'b0, CHK_NONE,    '0},
        '{CH_U,   1'b0, CHK_NONE,    '0},
        '{8'h44,  1'b0, CHK_NONE,    '0},
        '{8'h42,  1'b0, CHK_NONE,    '0},
        '{8'h46,  1'b0, CHK_NONE,    '0},
        '{8'h66,  1'b0, CHK_NONE,    '0},
        '{QUOTE,  1'b0, CHK_PREDICT, '0},
        '{QUOTE,  1'b0, CHK_NONE,    '0},
        '{8'h1F,  1'b0, CHK_ONE,     '{8'h00, KIND_ERROR, ERR_CONTROL, 1'b1}},
        '{QUOTE,  1'b0, CHK_NONE,    '0},
        '{BSLASH, 1'b0, CHK_NONE,    '0},
        '{8'h71,  1'b0, CHK_ONE,     '{8'h00, KIND_ERROR, ERR_ESCAPE, 1'b1}},
        '{QUOTE,  1'b0, CHK_NONE,    '0},
        '{BSLASH, 1'b0, CHK_NONE,    '0},
        '{CH_U,   1'b0, CHK_NONE,    '0},
        '{8'h7A,  1'b0, CHK_ONE,     '{8'h00, KIND_ERROR, ERR_HEX, 1'b1}},
        '{QUOTE,  1'b0, CHK_NONE,    '0},
        '{8'h00,  1'b1, CHK_ONE,     '{8'h00, KIND_ERROR, ERR_UNTERM, 1'b1}}
    };

    localparam logic [7:0] ESC_LETTERS [8] = '{
        QUOTE, BSLASH, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       text_end;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;

    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          burst_left = 0;

    utf8_res_t   utf8_due [$];
    utf8_res_t   step_res [$];
    text_item_t  text_q [$];

    // predictor state
    phase_t      ph;
    logic [15:0] acc;
    logic [1:0]  ndig;
    logic [15:0] hi_sur;

    json_string_unescape dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .text_end   (text_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .error_code (error_code),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout at cycle %0d, %0d results still due", cycle_count, utf8_due.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        end
    endtask

    // ---------------- predictor ----------------

    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b0, c[3:0]};
        end
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            return {1'b0, c[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    task automatic put_res(input logic [7:0] d, input logic [1:0] k, input logic [2:0] er);
        if (step_res.size() < MAX_RESULTS)
        begin
            step_res.push_back(utf8_res_t'{d, k, er, 1'b0});
        end
    endtask

    task automatic put_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            put_res(cp[7:0], KIND_DATA, ERR_NONE);
        end
        else if (cp < 21'h800)
        begin
            put_res({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
        else if (cp < 21'h10000)
        begin
            put_res({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
        else
        begin
            put_res({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
            put_res({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
        end
    endtask

    task automatic to_idle();
        ph = PH_IDLE;
        acc = '0;
        ndig = '0;
        hi_sur = '0;
    endtask

    task automatic abort_string(input logic [2:0] er);
        to_idle();
        put_res(8'h00, KIND_ERROR, er);
    endtask

    task automatic hex_complete(input logic [15:0] v);
        acc = '0;
        ndig = '0;
        if (v >= 16'hD800 && v < 16'hDC00)
        begin
            hi_sur = v;
            ph = PH_AFTER_HIGH;
        end
        else
        begin
            ph = PH_BODY;
            put_cp(v == 16'h0000 ? 21'h0FFFD : {5'd0, v});
        end
    endtask

    task automatic body_char(input logic [7:0] c);
        if (c == QUOTE)
        begin
            to_idle();
            put_res(8'h00, KIND_CLOSE, ERR_NONE);
        end
        else if (c < 8'h20)
        begin
            abort_string(ERR_CONTROL);
        end
        else if (c == BSLASH)
        begin
            ph = PH_ESC;
        end
        else
        begin
            put_res(c, KIND_DATA, ERR_NONE);
        end
    endtask

    task automatic esc_char(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        ok = 1'b1;
        d = c;
        case (c)
            8'h62: d = 8'h08;
            8'h66: d = 8'h0C;
            8'h6E: d = 8'h0A;
            8'h72: d = 8'h0D;
            8'h74: d = 8'h09;
            QUOTE, BSLASH, 8'h2F: d = c;
            default: ok = 1'b0;
        endcase
        if (c == CH_U)
        begin
            ph = PH_HEX;
            acc = '0;
            ndig = '0;
        end
        else if (!ok)
        begin
            abort_string(ERR_ESCAPE);
        end
        else
        begin
            ph = PH_BODY;
            put_res(d, KIND_DATA, ERR_NONE);
        end
    endtask

    task automatic unescape_step(input logic [7:0] c, input logic e);
        logic [4:0]  nib;
        logic [15:0] lo;
        logic [15:0] hi;
        utf8_res_t   tail;
        step_res.delete();
        nib = hex_nib(c);
        if (e)
        begin
            case (ph)
                PH_BODY, PH_ESC: abort_string(ERR_UNTERM);
                PH_HEX: abort_string(ERR_HEX);
                PH_AFTER_HIGH, PH_AFTER_HIGH_BS:
                begin
                    put_cp({5'd0, hi_sur});
                    abort_string(ERR_UNTERM);
                end
                PH_LOW_HEX:
                begin
                    put_cp({5'd0, hi_sur});
                    abort_string(ERR_HEX);
                end
                default: to_idle();
            endcase
        end
        else
        begin
            case (ph)
                PH_BODY: body_char(c);
                PH_ESC: esc_char(c);
                PH_HEX:
                begin
                    if (nib[4])
                    begin
                        abort_string(ERR_HEX);
                    end
                    else
                    begin
                        acc = {acc[11:0], nib[3:0]};
                        if (ndig == 2'd3)
                        begin
                            hex_complete(acc);
                        end
                        else
                        begin
                            ndig++;
                        end
                    end
                end
                PH_AFTER_HIGH:
                begin
                    if (c == BSLASH)
                    begin
                        ph = PH_AFTER_HIGH_BS;
                    end
                    else
                    begin
                        put_cp({5'd0, hi_sur});
                        hi_sur = '0;
                        ph = PH_BODY;
                        body_char(c);
                    end
                end
                PH_AFTER_HIGH_BS:
                begin
                    if (c == CH_U)
                    begin
                        ph = PH_LOW_HEX;
                        acc = '0;
                        ndig = '0;
                    end
                    else
                    begin
                        put_cp({5'd0, hi_sur});
                        hi_sur = '0;
                        ph = PH_ESC;
                        esc_char(c);
                    end
                end
                PH_LOW_HEX:
                begin
                    if (nib[4])
                    begin
                        put_cp({5'd0, hi_sur});
                        abort_string(ERR_HEX);
                    end
                    else
                    begin
                        acc = {acc[11:0], nib[3:0]};
                        if (ndig != 2'd3)
                        begin
                            ndig++;
                        end
                        else
                        begin
                            lo = acc;
                            hi = hi_sur;
                            hi_sur = '0;
                            if (lo >= 16'hDC00 && lo < 16'hE000)
                            begin
                                acc = '0;
                                ndig = '0;
                                ph = PH_BODY;
                                put_cp(21'h10000 + {1'b0, hi[9:0], lo[9:0]});
                            end
                            else
                            begin
                                put_cp({5'd0, hi});
                                hex_complete(lo);
                            end
                        end
                    end
                end
                default:
                begin
                    to_idle();
                    if (c == QUOTE)
                    begin
                        ph = PH_BODY;
                    end
                end
            endcase
        end
        if (step_res.size() > 0)
        begin
            tail = step_res.pop_back();
            tail.last = 1'b1;
            step_res.push_back(tail);
        end
    endtask

    // ---------------- text generation ----------------

    function automatic logic [7:0] hex_digit(input logic [3:0] n, input logic upper);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'h0, n};
        end
        return (upper ? 8'h37 : 8'h57) + {4'h0, n};
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(32, 255));
        while (v == QUOTE || v == BSLASH);
        return v;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] v;
        logic [4:0] n;
        do
        begin
            v = 8'($urandom_range(0, 255));
            n = hex_nib(v);
        end
        while (!n[4]);
        return v;
    endfunction

    function automatic logic [7:0] bad_letter();
        logic [7:0] v;
        logic       hit;
        do
        begin
            v = 8'($urandom_range(0, 255));
            hit = (v == CH_U);
            foreach (ESC_LETTERS[i])
            begin
                if (v == ESC_LETTERS[i])
                begin
                    hit = 1'b1;
                end
            end
        end
        while (hit);
        return v;
    endfunction

    task automatic add_item(input logic [7:0] b, input logic e);
        text_q.push_back(text_item_t'{b, e});
    endtask

    task automatic add_digits(input int k);
        repeat (k)
        begin
            add_item(hex_digit(4'($urandom), $urandom_range(0, 1) == 1), 1'b0);
        end
    endtask

    task automatic add_u(input logic [15:0] v);
        add_item(BSLASH, 1'b0);
        add_item(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--)
        begin
            add_item(hex_digit(v[4*i +: 4], $urandom_range(0, 1) == 1), 1'b0);
        end
    endtask

    task automatic add_simple_esc();
        add_item(BSLASH, 1'b0);
        add_item(ESC_LETTERS[$urandom_range(0, 7)], 1'b0);
    endtask

    task automatic add_single_cp();
        case ($urandom_range(0, 4))
            0: add_u(16'($urandom_range(0, 'h7F)));
            1: add_u(16'h0000);
            2: add_u(16'($urandom_range('h80, 'h7FF)));
            3: add_u(16'($urandom));
            default: add_u({6'b110111, 10'($urandom)});
        endcase
    endtask

    task automatic gen_string();
        int pick;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                add_item(non_hex_byte() == QUOTE ? 8'h00 : 8'($urandom_range(0, 255)) & 8'hDD,
                         1'b0);
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            add_item(8'($urandom_range(0, 255)), 1'b1);
        end
        add_item(QUOTE, 1'b0);
        repeat ($urandom_range(0, 8))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                add_item(plain_byte(), 1'b0);
            end
            else if (pick < 60)
            begin
                add_simple_esc();
            end
            else if (pick < 75)
            begin
                add_single_cp();
            end
            else if (pick < 87)
            begin
                add_u({6'b110110, 10'($urandom)});
                add_u({6'b110111, 10'($urandom)});
            end
            else
            begin
                // high surrogate followed by a plain byte, a simple escape, one \u escape or nothing
                add_u({6'b110110, 10'($urandom)});
                case ($urandom_range(0, 3))
                    0: add_item(plain_byte(), 1'b0);
                    1: add_simple_esc();
                    2: add_single_cp();
                    default: ;
                endcase
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            add_item(QUOTE, 1'b0);
        end
        else if (pick == 14)
        begin
            add_item(8'($urandom_range(0, 31)), 1'b0);
        end
        else if (pick == 15)
        begin
            add_item(BSLASH, 1'b0);
            add_item(bad_letter(), 1'b0);
        end
        else if (pick == 16)
        begin
            add_item(BSLASH, 1'b0);
            add_item(CH_U, 1'b0);
            add_digits($urandom_range(0, 3));
            add_item(non_hex_byte(), 1'b0);
        end
        else if (pick == 17)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                add_item(BSLASH, 1'b0);
            end
            add_item(8'($urandom_range(0, 255)), 1'b1);
        end
        else if (pick == 18)
        begin
            add_item(BSLASH, 1'b0);
            add_item(CH_U, 1'b0);
            add_digits($urandom_range(0, 3));
            add_item(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            // broken low half after a high surrogate
            add_u({6'b110110, 10'($urandom)});
            if ($urandom_range(0, 2) != 0)
            begin
                add_item(BSLASH, 1'b0);
                if ($urandom_range(0, 2) != 0)
                begin
                    add_item(CH_U, 1'b0);
                    add_digits($urandom_range(0, 3));
                end
            end
            if ($urandom_range(0, 1) == 1)
            begin
                add_item(non_hex_byte(), 1'b0);
            end
            else
            begin
                add_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // ---------------- driving ----------------

    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        text_end <= e;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        unescape_step(b, e);
    endtask

    initial
    begin : stim
        in_valid <= 1'b0;
        in_byte <= 8'h00;
        text_end <= 1'b0;
        rst_n <= 1'b0;
        to_idle();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i])
        begin
            send_item(DIR_ROWS[i].b, DIR_ROWS[i].e);
            case (DIR_ROWS[i].chk)
                CHK_PREDICT:
                begin
                    foreach (step_res[j])
                    begin
                        utf8_due.push_back(step_res[j]);
                    end
                end
                CHK_ONE: utf8_due.push_back(DIR_ROWS[i].want);
                default: ;
            endcase
        end

        while (text_q.size() < RANDOM_ITEMS)
        begin
            gen_string();
        end
        foreach (text_q[i])
        begin
            send_item(text_q[i].b, text_q[i].e);
            foreach (step_res[j])
            begin
                utf8_due.push_back(step_res[j]);
            end
        end
        in_valid <= 1'b0;

        while (utf8_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // receiver: random ready modes plus one long hold-off to back up the block
    initial
    begin : rx
        int n;
        int hold;
        int mode;
        n = 0;
        hold = 0;
        mode = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            n++;
            if (n == 150)
            begin
                hold = 60;
            end
            if (n % 32 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : mon
        utf8_res_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (utf8_due.size() == 0)
            begin
                report("result with nothing due, out_byte", out_byte, 0);
            end
            else
            begin
                w = utf8_due.pop_front();
                if (out_byte !== w.data)
                begin
                    report("out_byte", out_byte, w.data);
                end
                if (kind !== w.kind)
                begin
                    report("kind", kind, w.kind);
                end
                if (error_code !== w.err)
                begin
                    report("error_code", error_code, w.err);
                end
                if (last !== w.last)
                begin
                    report("last", last, w.last);
                end
            end
        end
    end

endmodule

@@ json_string_unescape.f @@
+incdir+hw/rtl
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_core.sv
hw/rtl/json_string_unescape.sv
test/tb_top.sv
